FILE: hw/rtl/pre_pkg.sv
// Package for the page replacement engine: command, status, policy and
// controller state codes, plus shared constants. No dependencies.
package pre_pkg;

    localparam logic [7:0]  AGE_FRESH = 8'h80;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_FAULT   = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TABLE     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_SWAP_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POL_NONE = 2'd0,
        POL_FIFO = 2'd1,
        POL_SC   = 2'd2,
        POL_NFU  = 2'd3
    } t_policy;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_MAXRES = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,     // lookup scan over all slots
        S_DECIDE,   // decide on eviction
        S_VSCAN,    // victim scan over slots
        S_VCHECK,   // second chance check of victim
        S_COMMIT,   // apply changes
        S_RELSCAN,  // release pass
        S_TICKSCAN, // aging pass
        S_OUT       // hold result
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_scan;   // restart slot index at zero
        logic step_scan;  // process current slot, advance index
        logic lookup;     // lookup mode during scan
        logic vsearch;    // victim search mode during scan
        logic release_op; // release mode during scan
        logic tick_op;    // aging mode during scan
        logic give_chance;// second chance on current best
        logic commit;     // commit alloc or fault
        logic set_nf;     // result status: not found
        logic set_tf;     // result status: table full
        logic set_sf;     // result status: swap full
        logic latch_in;   // capture transaction
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // index at last slot
        logic found;      // lookup hit
        logic need_evict; // eviction condition
        logic swap_free;  // a swap slot is free
        logic best_ok;    // victim candidate exists
        logic best_acc;   // accessed bit of candidate set
        logic sc_more;    // second chance retries remain
    } t_sts;

endpackage

FILE: hw/rtl/pre_ctrl.sv
// Controller state machine of the page replacement engine.
// Depends on pre_pkg.
module pre_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_cmd,
    input  logic [1:0]     i_policy,
    input  logic           i_out_ready,
    input  pre_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output pre_pkg::t_ctl  o_ctl
);
    pre_pkg::t_state r_state, n_state;
    logic [1:0]      r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pre_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= i_cmd;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            pre_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.latch_in = 1'b1;
                    o_ctl.clr_scan = 1'b1;
                    case (i_cmd)
                        pre_pkg::CMD_RELEASE: n_state = pre_pkg::S_RELSCAN;
                        pre_pkg::CMD_TICK:    n_state = pre_pkg::S_TICKSCAN;
                        default:              n_state = pre_pkg::S_SCAN;
                    endcase
                end
            end
            pre_pkg::S_SCAN: begin
                o_ctl.lookup    = 1'b1;
                o_ctl.step_scan = 1'b1;
                if (i_sts.scan_last) n_state = pre_pkg::S_DECIDE;
            end
            pre_pkg::S_DECIDE: begin
                o_ctl.clr_scan = 1'b1;
                if (!i_sts.found) begin
                    if (r_cmd == pre_pkg::CMD_ALLOC) o_ctl.set_tf = 1'b1;
                    else                             o_ctl.set_nf = 1'b1;
                    n_state = pre_pkg::S_OUT;
                end else if (!i_sts.need_evict) begin
                    n_state = pre_pkg::S_COMMIT;
                end else if (r_cmd == pre_pkg::CMD_ALLOC && !i_sts.swap_free) begin
                    o_ctl.set_sf = 1'b1;
                    n_state = pre_pkg::S_OUT;
                end else begin
                    n_state = pre_pkg::S_VSCAN;
                end
            end
            pre_pkg::S_VSCAN: begin
                o_ctl.vsearch   = 1'b1;
                o_ctl.step_scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = (i_policy == pre_pkg::POL_SC) ? pre_pkg::S_VCHECK
                                                            : pre_pkg::S_COMMIT;
                end
            end
            pre_pkg::S_VCHECK: begin
                // keep the candidate when committing; restart only on a retry
                if (i_sts.best_ok && i_sts.best_acc && i_sts.sc_more) begin
                    o_ctl.clr_scan    = 1'b1;
                    o_ctl.give_chance = 1'b1;
                    n_state = pre_pkg::S_VSCAN;
                end else begin
                    n_state = pre_pkg::S_COMMIT;
                end
            end
            pre_pkg::S_COMMIT: begin
                o_ctl.commit = 1'b1;
                n_state = pre_pkg::S_OUT;
            end
            pre_pkg::S_RELSCAN: begin
                o_ctl.release_op = 1'b1;
                o_ctl.step_scan  = 1'b1;
                if (i_sts.scan_last) n_state = pre_pkg::S_DECIDE;
            end
            pre_pkg::S_TICKSCAN: begin
                o_ctl.tick_op   = 1'b1;
                o_ctl.step_scan = 1'b1;
                if (i_sts.scan_last) n_state = pre_pkg::S_OUT;
            end
            pre_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = pre_pkg::S_IDLE;
            end
            default: n_state = pre_pkg::S_IDLE;
        endcase
        // release finishes after its pass; DECIDE then only reports
        if (r_state == pre_pkg::S_DECIDE && r_cmd == pre_pkg::CMD_RELEASE) begin
            o_ctl.set_tf = 1'b0;
            n_state = pre_pkg::S_OUT;
        end
    end
endmodule

FILE: hw/rtl/pre_datapath.sv
// Datapath of the page replacement engine: slot table, counters, scan
// index, victim tracking and result register. Depends on pre_pkg.
module pre_datapath #(
    parameter int unsigned SLOTS          = 32,
    parameter int unsigned RESERVED_SLOTS = 3,
    parameter int unsigned SWAP_SLOTS     = 16,
    parameter int unsigned PAGE_BITS      = 20,
    parameter int unsigned SEQ_WIDTH      = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pre_pkg::t_ctl          i_ctl,
    input  logic [1:0]             i_cmd,
    input  logic [PAGE_BITS-1:0]   i_page_number,
    input  logic [31:0]            i_accessed_bits,
    input  logic                   i_exempt,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [5:0]             i_cfg_data,
    output logic [1:0]             o_policy,
    output pre_pkg::t_sts          o_sts,
    output logic [4:0]             o_slot,
    output logic                   o_evicted,
    output logic [4:0]             o_victim_slot,
    output logic [PAGE_BITS-1:0]   o_victim_page,
    output logic [3:0]             o_swap_slot,
    output logic [31:0]            o_clear_accessed_mask,
    output logic [1:0]             o_status,
    output logic [5:0]             o_resident_count,
    output logic [5:0]             o_swapped_count
);
    localparam int unsigned IW  = $clog2(SLOTS);
    localparam int unsigned SWW = $clog2(SWAP_SLOTS);
    localparam int unsigned CW  = $clog2(SLOTS + 2);

    // slot table: per-entry flags, fields in memories
    logic [SLOTS-1:0]       r_valid, r_res;
    logic [PAGE_BITS-1:0]   r_page [SLOTS];
    logic [SEQ_WIDTH-1:0]   r_seq  [SLOTS];
    logic [7:0]             r_age  [SLOTS];
    logic [SWW-1:0]         r_swap [SLOTS];
    logic [SWAP_SLOTS-1:0]  r_swap_use;
    logic [SEQ_WIDTH-1:0]   r_next_seq;
    logic [5:0]             r_res_tot, r_swp_tot;
    logic [1:0]             r_policy;
    logic [5:0]             r_max_res;

    // transaction capture
    logic [1:0]             r_cmd;
    logic [PAGE_BITS-1:0]   r_pg;
    logic [31:0]            r_acc;
    logic                   r_exempt;

    // scan state
    logic [IW-1:0]          r_idx;
    logic                   r_found;
    logic [IW-1:0]          r_fidx;
    logic                   r_best_ok;
    logic [IW-1:0]          r_best;
    logic [SEQ_WIDTH-1:0]   r_best_d;
    logic [7:0]             r_best_age;
    logic [CW-1:0]          r_tries;

    // result
    logic [4:0]             r_o_slot, r_o_vslot;
    logic                   r_o_evd;
    logic [PAGE_BITS-1:0]   r_o_vpage;
    logic [3:0]             r_o_sw;
    logic [31:0]            r_clr;
    logic [1:0]             r_st;

    // lowest free swap slot
    logic               free_ok;
    logic [SWW-1:0]     free_idx;
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int k = SWAP_SLOTS - 1; k >= 0; k--) begin
            if (!r_swap_use[k]) begin
                free_ok  = 1'b1;
                free_idx = SWW'(k);
            end
        end
    end

    logic               cur_elig, cur_acc, best_acc;
    logic [SEQ_WIDTH-1:0] cur_d;
    logic               cur_hit;
    assign cur_elig = r_valid[r_idx] && r_res[r_idx] && (32'(r_idx) >= RESERVED_SLOTS);
    assign cur_acc  = (32'(r_idx) < 32) ? r_acc[5'(r_idx)] : 1'b0;
    assign best_acc = (32'(r_best) < 32) ? r_acc[5'(r_best)] : 1'b0;
    assign cur_d    = r_next_seq - r_seq[r_idx];
    assign cur_hit  = r_valid[r_idx] && (r_page[r_idx] == r_pg) &&
                      !(r_cmd == pre_pkg::CMD_FAULT && r_res[r_idx]);

    logic need;
    assign need = (r_policy != pre_pkg::POL_NONE) && (r_res_tot >= r_max_res) &&
                  !(r_cmd == pre_pkg::CMD_ALLOC && r_exempt);

    assign o_sts.scan_last  = (32'(r_idx) == SLOTS - 1);
    assign o_sts.found      = r_found;
    assign o_sts.need_evict = need;
    assign o_sts.swap_free  = free_ok;
    assign o_sts.best_ok    = r_best_ok;
    assign o_sts.best_acc   = best_acc;
    assign o_sts.sc_more    = (32'(r_tries) <= SLOTS);
    assign o_policy         = r_policy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= pre_pkg::POL_FIFO;
            r_max_res <= 6'd15;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pre_pkg::REG_POLICY) r_policy  <= i_cfg_data[1:0];
            else                                    r_max_res <= i_cfg_data;
        end
    end

    // main datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_res      <= '0;
            r_swap_use <= '0;
            r_next_seq <= '0;
            r_res_tot  <= '0;
            r_swp_tot  <= '0;
            r_idx      <= '0;
        end else begin
            if (i_ctl.latch_in) begin
                r_cmd    <= i_cmd;
                r_pg     <= i_page_number;
                r_acc    <= i_accessed_bits;
                r_exempt <= i_exempt;
                r_found  <= 1'b0;
                r_fidx   <= '0;
                r_tries  <= '0;
                r_clr    <= '0;
                r_st     <= pre_pkg::ST_OK;
                r_o_slot <= '0;
                r_o_evd  <= 1'b0;
                r_o_vslot <= '0;
                r_o_vpage <= '0;
                r_o_sw   <= '0;
            end
            if (i_ctl.clr_scan) begin
                r_idx     <= '0;
                r_best_ok <= 1'b0;
            end
            if (i_ctl.step_scan) begin
                r_idx <= r_idx + IW'(1);
            end
            // lookup: first free slot for allocate, first match otherwise
            if (i_ctl.lookup && !r_found) begin
                if (r_cmd == pre_pkg::CMD_ALLOC ? !r_valid[r_idx] : cur_hit) begin
                    r_found <= 1'b1;
                    r_fidx  <= r_idx;
                end
            end
            // victim search
            if (i_ctl.vsearch && cur_elig) begin
                if (r_policy == pre_pkg::POL_NFU) begin
                    if (!r_best_ok || r_age[r_idx] <= r_best_age) begin
                        r_best_ok  <= 1'b1;
                        r_best     <= r_idx;
                        r_best_age <= r_age[r_idx];
                    end
                end else if (!r_best_ok || cur_d > r_best_d) begin
                    r_best_ok <= 1'b1;
                    r_best    <= r_idx;
                    r_best_d  <= cur_d;
                end
            end
            if (i_ctl.give_chance) begin
                r_acc[5'(r_best)] <= 1'b0;
                r_clr[5'(r_best)] <= 1'b1;
                r_seq[r_best]     <= r_next_seq;
                r_next_seq        <= r_next_seq + SEQ_WIDTH'(1);
                r_tries           <= r_tries + CW'(1);
            end
            // release pass
            if (i_ctl.release_op && r_valid[r_idx] && r_page[r_idx] == r_pg) begin
                if (!r_found) begin
                    r_found  <= 1'b1;
                    r_o_slot <= 5'(r_idx);
                end
                r_valid[r_idx] <= 1'b0;
                r_res[r_idx]   <= 1'b0;
                if (r_res[r_idx]) begin
                    if (r_res_tot != 0) r_res_tot <= r_res_tot - 6'd1;
                end else begin
                    if (r_swp_tot != 0) r_swp_tot <= r_swp_tot - 6'd1;
                    r_swap_use[r_swap[r_idx]] <= 1'b0;
                end
            end
            // aging pass
            if (i_ctl.tick_op && r_valid[r_idx] && r_res[r_idx]) begin
                r_age[r_idx] <= {cur_acc, r_age[r_idx][7:1]};
                if (cur_acc) r_clr[5'(r_idx)] <= 1'b1;
            end
            if (i_ctl.set_nf) r_st <= pre_pkg::ST_NOT_FOUND;
            if (i_ctl.set_tf) r_st <= pre_pkg::ST_TABLE;
            if (i_ctl.set_sf) r_st <= pre_pkg::ST_SWAP_FULL;
            // commit allocate or fault-in
            if (i_ctl.commit) begin : commit_blk
                logic             ev;
                logic [SWW-1:0]   fs;
                logic [SEQ_WIDTH-1:0] sq;
                logic [SWAP_SLOTS-1:0] use_n;
                logic [SLOTS-1:0] res_n;
                logic [3:0]       sw_n;
                ev    = need && r_best_ok;
                use_n = r_swap_use;
                res_n = r_res;
                sq    = r_next_seq;
                sw_n  = '0;
                r_o_slot <= 5'(r_fidx);
                if (r_cmd == pre_pkg::CMD_FAULT) begin
                    use_n[r_swap[r_fidx]] = 1'b0;
                    sw_n = 4'(r_swap[r_fidx]);
                end
                fs = '0;
                for (int k = SWAP_SLOTS - 1; k >= 0; k--)
                    if (!use_n[k]) fs = SWW'(k);
                if (ev) begin
                    use_n[fs]      = 1'b1;
                    res_n[r_best]  = 1'b0;
                    r_swap[r_best] <= fs;
                    r_seq[r_best]  <= sq;
                    sq             = sq + SEQ_WIDTH'(1);
                    sw_n           = 4'(fs);
                    r_o_evd   <= 1'b1;
                    r_o_vslot <= 5'(r_best);
                    r_o_vpage <= r_page[r_best];
                end
                if (r_cmd == pre_pkg::CMD_ALLOC) begin
                    if (ev) r_swp_tot <= r_swp_tot + 6'd1;
                    else    r_res_tot <= r_res_tot + 6'd1;
                    r_valid[r_fidx] <= 1'b1;
                    r_page[r_fidx]  <= r_pg;
                    r_seq[r_fidx]   <= sq;
                    r_swap[r_fidx]  <= '0;
                    sq              = sq + SEQ_WIDTH'(1);
                end else if (!ev) begin
                    if (r_swp_tot != 0) r_swp_tot <= r_swp_tot - 6'd1;
                    r_res_tot <= r_res_tot + 6'd1;
                end
                res_n[r_fidx] = 1'b1;
                r_res         <= res_n;
                r_o_sw        <= sw_n;
                r_age[r_fidx] <= pre_pkg::AGE_FRESH;
                r_swap_use    <= use_n;
                r_next_seq    <= sq;
            end
        end
    end

    assign o_slot                = r_o_slot;
    assign o_evicted             = r_o_evd;
    assign o_victim_slot         = r_o_vslot;
    assign o_victim_page         = r_o_vpage;
    assign o_swap_slot           = r_o_sw;
    assign o_clear_accessed_mask = r_clr;
    assign o_status              = r_st;
    assign o_resident_count      = r_res_tot;
    assign o_swapped_count       = r_swp_tot;
endmodule

FILE: hw/rtl/page_replacement_engine.sv
// Top level of the page replacement engine: stream ports, config port,
// controller and datapath. Depends on pre_pkg, pre_ctrl, pre_datapath.
//
//  channel  | signals                 | moves
//  s_axis   | tvalid tready tdata     | command transaction in
//  m_axis   | tvalid tready tdata     | result transaction out
//  cfg      | valid ready index data  | register write
//
// Each pass visits one slot per cycle. Tick runs the aging pass; release runs
// the release pass and then reports. Allocate and fault-in run the lookup
// scan and the decision, then a victim pass if eviction is needed, then the
// commit; not found, table full and swap full report after the lookup scan.
// Second chance repeats the victim pass per retry, at most SLOTS+1 retries.
// Reset is synchronous, active low. A result holds until taken; the next
// transaction can be accepted in the cycle after that.
module page_replacement_engine #(
    parameter int unsigned SLOTS          = 32,
    parameter int unsigned RESERVED_SLOTS = 3,
    parameter int unsigned SWAP_SLOTS     = 16,
    parameter int unsigned PAGE_BITS      = 20,
    parameter int unsigned SEQ_WIDTH      = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // cmd, page_number, accessed_bits, exempt, zero fill
    input  logic [((35 + PAGE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // slot, evicted, victim_slot, victim_page, swap_slot,
    // clear_accessed_mask, status, resident_count, swapped_count, zero fill
    output logic [((61 + PAGE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_index,
    input  logic [5:0] i_cfg_data
);
    localparam int unsigned OW = ((61 + PAGE_BITS + 7) / 8) * 8;
    localparam int unsigned P  = PAGE_BITS;

    pre_pkg::t_ctl ctl;
    pre_pkg::t_sts sts;
    logic [1:0]    policy;
    logic [4:0]    slot, vslot;
    logic          evd;
    logic [P-1:0]  vpage;
    logic [3:0]    sw;
    logic [31:0]   clr;
    logic [1:0]    st;
    logic [5:0]    rc, sc;

    assign o_cfg_ready = 1'b1;

    pre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tdata[1:0]),
        .i_policy   (policy),
        .i_out_ready(m_axis_tready),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_ctl      (ctl)
    );

    pre_datapath #(
        .SLOTS(SLOTS), .RESERVED_SLOTS(RESERVED_SLOTS), .SWAP_SLOTS(SWAP_SLOTS),
        .PAGE_BITS(PAGE_BITS), .SEQ_WIDTH(SEQ_WIDTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (ctl),
        .i_cmd                (s_axis_tdata[1:0]),
        .i_page_number        (s_axis_tdata[P+1:2]),
        .i_accessed_bits      (s_axis_tdata[P+33:P+2]),
        .i_exempt             (s_axis_tdata[P+34]),
        .i_cfg_we             (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_policy             (policy),
        .o_sts                (sts),
        .o_slot               (slot),
        .o_evicted            (evd),
        .o_victim_slot        (vslot),
        .o_victim_page        (vpage),
        .o_swap_slot          (sw),
        .o_clear_accessed_mask(clr),
        .o_status             (st),
        .o_resident_count     (rc),
        .o_swapped_count      (sc)
    );

    assign m_axis_tdata = OW'({sc, rc, st, clr, sw, vpage, vslot, evd, slot});
endmodule
